@@ rtl/kdr_pkg.sv @@
// shared constants and types for the keypad debounce, repeat and chord block
`timescale 1ns / 1ps

package kdr_pkg;

  localparam int NUM_KEYS = 5;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0]    REPEAT_PERIOD_RST = CNT_W'(10);
  localparam logic [CNT_W-1:0]    CHORD_HOLD_RST    = CNT_W'(40);
  localparam logic [NUM_KEYS-1:0] REPEAT_KEYS_RST   = NUM_KEYS'(12);
  localparam logic [NUM_KEYS-1:0] CHORD_KEYS_RST    = NUM_KEYS'(17);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_PERIOD = 2'd0,
    CFG_CHORD_HOLD    = 2'd1,
    CFG_REPEAT_KEYS   = 2'd2,
    CFG_CHORD_KEYS    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic active;  // every chord key held, events suppressed
    logic menu;    // hold time reached on this tick
  } chord_stat_t;

endpackage

@@ rtl/kdr_key_lane.sv @@
// per-key auto-repeat conditioning with its own repeat counter
`timescale 1ns / 1ps

module kdr_key_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      held,
  input  logic                      repeat_en,
  input  logic [kdr_pkg::CNT_W-1:0] period,
  output logic                      pressed
);

  logic [kdr_pkg::CNT_W-1:0] count_r;
  logic [kdr_pkg::CNT_W-1:0] count_nxt;

  always_comb begin
    pressed   = 1'b0;
    count_nxt = count_r;
    if (held) begin
      if (repeat_en) begin
        if (count_r >= period) begin
          // forced released tick
          count_nxt = '0;
        end else begin
          pressed   = 1'b1;
          count_nxt = count_r + kdr_pkg::CNT_W'(1);
        end
      end else begin
        pressed = 1'b1;
      end
    end else begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/kdr_chord.sv @@
// chord detection and hold timer for the menu event
`timescale 1ns / 1ps

module kdr_chord (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [kdr_pkg::NUM_KEYS-1:0] held,
  input  logic [kdr_pkg::NUM_KEYS-1:0] chord_keys,
  input  logic [kdr_pkg::CNT_W-1:0]    chord_hold,
  output kdr_pkg::chord_stat_t         stat
);

  logic [kdr_pkg::CNT_W-1:0] timer_r;
  logic [kdr_pkg::CNT_W-1:0] timer_nxt;
  logic [kdr_pkg::CNT_W-1:0] timer_inc;

  assign timer_inc = timer_r + kdr_pkg::CNT_W'(1);

  always_comb begin
    stat.active = (chord_keys != '0) && ((held & chord_keys) == chord_keys);
    stat.menu   = 1'b0;
    timer_nxt   = '0;
    if (stat.active) begin
      if (timer_inc >= chord_hold) begin
        stat.menu = 1'b1;
      end else begin
        timer_nxt = timer_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else if (advance) begin
      timer_r <= timer_nxt;
    end
  end

  // timer only runs while the chord is held
  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) && !$past(stat.active) |-> timer_r == '0)
    else $error("chord timer not cleared after chord release");

  a_menu_needs_chord: assert property (@(posedge clk) disable iff (!rst_n)
    stat.menu |-> stat.active && chord_keys != '0)
    else $error("menu event without an active chord");

endmodule

@@ rtl/keypad_debounce_repeat_chord.sv @@
// top level: keypad debounce with auto-repeat and a menu chord
`timescale 1ns / 1ps

// One transaction on the input channel is one scan tick carrying the raw,
// active-low key levels; each tick gives exactly one result transaction with
// press, release and menu event masks. The block takes one tick per clock
// cycle when the result side keeps up: a tick is captured in the input
// register, all keys are worked in parallel by the per-key repeat lanes, the
// three-sample history and the chord timer, and the result is then registered
// in the output register, from which it is taken. A stall on the result side
// holds the output register; while it is full the input register still takes
// one more tick, and in_stall rises only when both are occupied. Configuration
// is written through the cfg_ channel, always ready, and is meant to change
// only while no tick is in flight. Reset brings every configuration
// register to its documented default and clears history, repeat counters and
// the chord timer.

module keypad_debounce_repeat_chord (
  input  logic                           clk,
  input  logic                           rst_n,
  // scan tick input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kdr_pkg::NUM_KEYS-1:0]   in_key_levels,
  // event output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kdr_pkg::NUM_KEYS-1:0]   out_press_events,
  output logic [kdr_pkg::NUM_KEYS-1:0]   out_release_events,
  output logic                           out_menu_event,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [kdr_pkg::CNT_W-1:0]    repeat_period_r;
  logic [kdr_pkg::CNT_W-1:0]    chord_hold_r;
  logic [kdr_pkg::NUM_KEYS-1:0] repeat_keys_r;
  logic [kdr_pkg::NUM_KEYS-1:0] chord_keys_r;

  // input stage
  logic                         in_full_r;
  logic                         in_full_nxt;
  logic [kdr_pkg::NUM_KEYS-1:0] levels_r;

  // history of conditioned pressed bits
  logic [kdr_pkg::NUM_KEYS-1:0] hist_newer_r;
  logic [kdr_pkg::NUM_KEYS-1:0] hist_older_r;

  // output stage
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [kdr_pkg::NUM_KEYS-1:0] press_r;
  logic [kdr_pkg::NUM_KEYS-1:0] release_r;
  logic                         menu_r;

  logic                         in_take;
  logic                         out_room;
  logic                         advance;
  logic [kdr_pkg::NUM_KEYS-1:0] held;
  logic [kdr_pkg::NUM_KEYS-1:0] cur;
  logic [kdr_pkg::NUM_KEYS-1:0] press_nxt;
  logic [kdr_pkg::NUM_KEYS-1:0] release_nxt;
  kdr_pkg::chord_stat_t         chord_stat;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_period_r <= kdr_pkg::REPEAT_PERIOD_RST;
      chord_hold_r    <= kdr_pkg::CHORD_HOLD_RST;
      repeat_keys_r   <= kdr_pkg::REPEAT_KEYS_RST;
      chord_keys_r    <= kdr_pkg::CHORD_KEYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kdr_pkg::CFG_REPEAT_PERIOD: repeat_period_r <= cfg_data[kdr_pkg::CNT_W-1:0];
        kdr_pkg::CFG_CHORD_HOLD:    chord_hold_r    <= cfg_data[kdr_pkg::CNT_W-1:0];
        kdr_pkg::CFG_REPEAT_KEYS:   repeat_keys_r   <= cfg_data[kdr_pkg::NUM_KEYS-1:0];
        kdr_pkg::CFG_CHORD_KEYS:    chord_keys_r    <= cfg_data[kdr_pkg::NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the output register frees up when it is empty or being taken
  assign out_room    = !out_valid_r || !out_stall;
  assign advance     = in_full_r && out_room;
  assign in_stall    = in_full_r && !out_room;
  assign in_take     = in_valid && !in_stall;
  assign in_full_nxt = in_take || (in_full_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      levels_r <= in_key_levels;
    end
  end

  // active-low pins
  assign held = ~levels_r;

  // one repeat lane per key
  for (genvar k = 0; k < kdr_pkg::NUM_KEYS; k++) begin : g_lane
    kdr_key_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .held      (held[k]),
      .repeat_en (repeat_keys_r[k]),
      .period    (repeat_period_r),
      .pressed   (cur[k])
    );
  end

  kdr_chord u_chord (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .held       (held),
    .chord_keys (chord_keys_r),
    .chord_hold (chord_hold_r),
    .stat       (chord_stat)
  );

  // press needs 0,1,1 and release 1,0,0 across older, newer, current;
  // both are masked while the chord is held
  always_comb begin
    press_nxt   = ~hist_older_r & hist_newer_r & cur;
    release_nxt = hist_older_r & ~hist_newer_r & ~cur;
    if (chord_stat.active) begin
      press_nxt   = '0;
      release_nxt = '0;
    end
  end

  // history keeps shifting even while the chord suppresses events
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_newer_r <= '0;
      hist_older_r <= '0;
    end else if (advance) begin
      hist_older_r <= hist_newer_r;
      hist_newer_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_r   <= press_nxt;
      release_r <= release_nxt;
      menu_r    <= chord_stat.menu;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_press_events   = press_r;
  assign out_release_events = release_r;
  assign out_menu_event     = menu_r;

  // a key cannot both press and release in the same transaction
  a_no_press_and_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (press_r & release_r) == '0)
    else $error("press and release on the same key");

  // a menu event always comes with suppressed key events
  a_menu_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && menu_r |-> press_r == '0 && release_r == '0)
    else $error("key events alongside menu event");

  // a stalled result with a full input stage must hold off the source
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && out_valid_r && out_stall |-> in_stall)
    else $error("input accepted with both stages full");

  // work advances only into a free output register
  a_advance_room: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick lost before output");

endmodule

@@ sim/tb_keypad_debounce_repeat_chord.sv @@
// testbench for the keypad debounce, auto-repeat and menu chord block
`timescale 1ns / 1ps

module tb_keypad_debounce_repeat_chord;

  // idle cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // cycles to let the pipeline settle once the last event result is in
  localparam int SETTLE_CYCLES = 4;
  localparam int GAP_PCT = 24;

  typedef struct packed {
    logic [kdr_pkg::NUM_KEYS-1:0] press;
    logic [kdr_pkg::NUM_KEYS-1:0] rel_mask;
    logic                         menu;
  } key_events_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [kdr_pkg::NUM_KEYS-1:0]   in_key_levels;
  logic                           out_valid;
  logic                           out_stall;
  logic [kdr_pkg::NUM_KEYS-1:0]   out_press_events;
  logic [kdr_pkg::NUM_KEYS-1:0]   out_release_events;
  logic                           out_menu_event;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [kdr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kdr_pkg::CFG_DATA_W-1:0] cfg_data;

  keypad_debounce_repeat_chord DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_levels      (in_key_levels),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_press_events   (out_press_events),
    .out_release_events (out_release_events),
    .out_menu_event     (out_menu_event),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // shadow of the block's registers, kept in step with every write
  logic [kdr_pkg::CNT_W-1:0]    period_r;
  logic [kdr_pkg::CNT_W-1:0]    hold_r;
  logic [kdr_pkg::NUM_KEYS-1:0] rkeys_r;
  logic [kdr_pkg::NUM_KEYS-1:0] ckeys_r;

  // shadow of the block's scan state
  logic [kdr_pkg::NUM_KEYS-1:0] hist_newer;
  logic [kdr_pkg::NUM_KEYS-1:0] hist_older;
  logic [kdr_pkg::CNT_W-1:0]    rep_cnt [kdr_pkg::NUM_KEYS];
  logic [kdr_pkg::CNT_W-1:0]    chord_tmr;

  // event masks still owed by the block, oldest first
  key_events_t pending_events[$];

  // random idling on both channels; cleared for a stretch of back-to-back traffic
  bit gaps_on;

  int n_ticks;
  int n_results;
  int n_menu;
  int n_press;
  int n_release;
  int n_settings;
  int n_fail;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // next event masks for one scan tick; advances the shadow state
  function automatic void scan_keys(input logic [kdr_pkg::NUM_KEYS-1:0] levels);
    logic [kdr_pkg::NUM_KEYS-1:0] held;
    logic [kdr_pkg::NUM_KEYS-1:0] cur;
    key_events_t                  ev;
    held = ~levels;
    cur  = '0;
    for (int k = 0; k < kdr_pkg::NUM_KEYS; k++) begin
      if (held[k]) begin
        if (rkeys_r[k]) begin
          // count at or past the period: forced released tick
          if (rep_cnt[k] >= period_r) begin
            rep_cnt[k] = '0;
          end else begin
            cur[k]     = 1'b1;
            rep_cnt[k] = rep_cnt[k] + 1'b1;
          end
        end else begin
          cur[k] = 1'b1;
        end
      end else begin
        rep_cnt[k] = '0;
      end
    end
    // rising edge needs 0,1,1 and falling edge 1,0,0 over the history
    ev.press    = ~hist_older & hist_newer & cur;
    ev.rel_mask = hist_older & ~hist_newer & ~cur;
    ev.menu     = 1'b0;
    hist_older  = hist_newer;
    hist_newer  = cur;
    // full chord held: events masked, hold timer runs; history keeps shifting
    if (ckeys_r != '0 && (held & ckeys_r) == ckeys_r) begin
      ev.press    = '0;
      ev.rel_mask = '0;
      chord_tmr   = chord_tmr + 1'b1;
      if (chord_tmr >= hold_r) begin
        chord_tmr = '0;
        ev.menu   = 1'b1;
      end
    end else begin
      chord_tmr = '0;
    end
    pending_events.push_back(ev);
  endfunction

  // one scan tick transaction, with an optional random idle gap first
  task automatic send_tick(input logic [kdr_pkg::NUM_KEYS-1:0] levels);
    bit taken;
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_key_levels <= levels;
    // in_stall only moves on a rising edge, so the falling edge is a safe look
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    scan_keys(levels);
    n_ticks++;
  endtask

  // stop sending and wait until every owed result is in and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; cfg_valid is left high for a following write
  task automatic write_reg(input kdr_pkg::cfg_idx_t idx,
                           input logic [kdr_pkg::CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      kdr_pkg::CFG_REPEAT_PERIOD: period_r = data;
      kdr_pkg::CFG_CHORD_HOLD:    hold_r   = data;
      kdr_pkg::CFG_REPEAT_KEYS:   rkeys_r  = data[kdr_pkg::NUM_KEYS-1:0];
      kdr_pkg::CFG_CHORD_KEYS:    ckeys_r  = data[kdr_pkg::NUM_KEYS-1:0];
      default: ;
    endcase
  endtask

  // writes all four registers once the block is idle; junk in the unused
  // upper bits of the mask writes must be ignored
  task automatic set_config(input logic [kdr_pkg::CNT_W-1:0] period,
                            input logic [kdr_pkg::CNT_W-1:0] hold,
                            input logic [kdr_pkg::NUM_KEYS-1:0] rkeys,
                            input logic [kdr_pkg::NUM_KEYS-1:0] ckeys);
    drain();
    write_reg(kdr_pkg::CFG_REPEAT_PERIOD, period);
    write_reg(kdr_pkg::CFG_CHORD_HOLD, hold);
    write_reg(kdr_pkg::CFG_REPEAT_KEYS, {3'($urandom_range(7)), rkeys});
    write_reg(kdr_pkg::CFG_CHORD_KEYS, {3'($urandom_range(7)), ckeys});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // same levels for a run of ticks
  task automatic hold_levels(input logic [kdr_pkg::NUM_KEYS-1:0] levels, input int ticks);
    repeat (ticks) send_tick(levels);
  endtask

  // reset defaults: plain key, repeat key and the default chord
  task automatic test_reset_defaults();
    send_tick(5'b11111);
    hold_levels(5'b11110, 3);   // key 0 has no repeat: one press
    hold_levels(5'b11111, 3);   // and one release
    send_tick(5'b00000);        // every key down holds the default chord
    send_tick(5'b11111);
  endtask

  // auto-repeat at the shortest period, at zero, and with the period cut mid-count
  task automatic test_auto_repeat();
    set_config(8'd1, 8'd1, 5'b11111, 5'b00000);
    hold_levels(5'b00000, 6);   // pressed and released alternate, no two pressed in a row
    send_tick(5'b11111);
    set_config(8'd0, 8'd1, 5'b11111, 5'b00000);
    hold_levels(5'b00000, 3);   // zero period: never reads pressed
    send_tick(5'b11111);
    set_config(8'd6, 8'd1, 5'b00001, 5'b00000);
    hold_levels(5'b11110, 4);
    // period lowered under the running count: next tick is the forced release
    set_config(8'd2, 8'd1, 5'b00001, 5'b00000);
    hold_levels(5'b11110, 3);
    send_tick(5'b11111);
  endtask

  // chord with zero hold time, then a short hold broken by a key release
  task automatic test_menu_chord();
    set_config(8'd10, 8'd0, 5'b00000, 5'b11111);
    hold_levels(5'b00000, 2);   // zero hold: menu on every held tick
    send_tick(5'b11111);
    set_config(8'd10, 8'd2, 5'b00000, 5'b00011);
    hold_levels(5'b11100, 3);
    send_tick(5'b11101);        // chord broken: timer restarts
    hold_levels(5'b11100, 2);
    send_tick(5'b11111);
  endtask

  // random key sequences over several register settings
  task automatic test_random_scans(input int ticks_per_setting);
    logic [kdr_pkg::NUM_KEYS-1:0] levels;
    int                           sent;
    int                           len;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(8'd255, 8'd255, 5'b11111, 5'b00001);
        1: set_config(8'd1, 8'd1, 5'b00000, 5'b00000);
        2: set_config(8'd0, 8'd0, 5'b11111, 5'b11111);
        default: set_config(8'($urandom_range(0, 12)), 8'($urandom_range(0, 15)),
                            5'($urandom), 5'($urandom));
      endcase
      // one setting runs back to back on both channels
      gaps_on = (ph != 3);
      sent = 0;
      // the longest hold and repeat counts only show up after a long chord
      if (ph == 0) begin
        hold_levels(5'($urandom) & 5'b11110, 260);
      end
      while (sent < ticks_per_setting) begin
        if ($urandom_range(99) < 25) begin
          // noise: one tick of arbitrary levels
          send_tick(5'($urandom));
          sent++;
        end else begin
          // held pattern, often with the whole chord down
          if ($urandom_range(99) < 30) levels = 5'($urandom) & ~ckeys_r;
          else levels = 5'($urandom);
          if ($urandom_range(9) == 0) len = $urandom_range(20, 40);
          else len = $urandom_range(1, 12);
          hold_levels(levels, len);
          sent += len;
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // result side stalls at random while gaps are on
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
  end

  // outputs only move on rising edges: look at the falling edge, and a
  // result seen valid and unstalled here is taken at the next rising edge
  always @(negedge clk) begin
    key_events_t exp_ev;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_events.size() == 0) begin
          $error("event result with no scan tick waiting for it");
          n_fail++;
        end else begin
          exp_ev = pending_events.pop_front();
          if (out_press_events !== exp_ev.press) begin
            $error("press_events: expected %b, got %b", exp_ev.press, out_press_events);
            n_fail++;
          end
          if (out_release_events !== exp_ev.rel_mask) begin
            $error("release_events: expected %b, got %b", exp_ev.rel_mask,
                   out_release_events);
            n_fail++;
          end
          if (out_menu_event !== exp_ev.menu) begin
            $error("menu_event: expected %b, got %b", exp_ev.menu, out_menu_event);
            n_fail++;
          end
          if (exp_ev.menu) n_menu++;
          if (exp_ev.press != '0) n_press++;
          if (exp_ev.rel_mask != '0) n_release++;
        end
      end
    end
  end

  initial begin
    // reset values of the registers and a clear scan state
    period_r   = kdr_pkg::REPEAT_PERIOD_RST;
    hold_r     = kdr_pkg::CHORD_HOLD_RST;
    rkeys_r    = kdr_pkg::REPEAT_KEYS_RST;
    ckeys_r    = kdr_pkg::CHORD_KEYS_RST;
    hist_newer = '0;
    hist_older = '0;
    chord_tmr  = '0;
    for (int k = 0; k < kdr_pkg::NUM_KEYS; k++) rep_cnt[k] = '0;
    gaps_on      = 1'b1;
    n_ticks      = 0;
    n_results    = 0;
    n_menu       = 0;
    n_press      = 0;
    n_release    = 0;
    n_settings   = 0;
    n_fail       = 0;
    quiet_cycles = 0;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_key_levels <= '1;
    cfg_valid     <= 1'b0;
    cfg_index     <= kdr_pkg::CFG_REPEAT_PERIOD;
    cfg_data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_auto_repeat();
    test_menu_chord();
    test_random_scans(25);
    drain();

    if (pending_events.size() != 0) begin
      $error("%0d event results never arrived", pending_events.size());
      n_fail++;
    end
    $display("run covered %0d scan ticks and %0d results over %0d register settings",
             n_ticks, n_results, n_settings);
    $display("results with press: %0d, with release: %0d, with menu: %0d",
             n_press, n_release, n_menu);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
